[hw/rtl/qse_pkg.sv]
// ----------------------------------------------------------------------------
// qse_pkg
// Shared widths and types for the quicksort engine.
// ----------------------------------------------------------------------------
package qse_pkg;

  // Element store size and the widths that follow from it.
  localparam int DEPTH       = 64;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Range stack size.
  localparam int STACK_DEPTH = 64;
  localparam int STK_ADDR_W  = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // One stack entry holds the bounds of a range still to be partitioned.
  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  localparam int RANGE_W = $bits(range_t);

endpackage

[hw/rtl/qse_if.sv]
// ----------------------------------------------------------------------------
// qse_if
// Valid/ready channels for the input and result items of the quicksort engine.
// ----------------------------------------------------------------------------

// Input channel: one value per item, last marks the end of a set.
interface qse_in_if import qse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

// Result channel: sorted values in ascending order.
interface qse_out_if import qse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     end_of_set;

  modport source (output valid, sorted_value, end_of_set, input ready);
  modport sink   (input valid, sorted_value, end_of_set, output ready);
endinterface

[hw/rtl/qse_ram.sv]
// ----------------------------------------------------------------------------
// qse_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data. A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module qse_ram #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // Write and read in the same edge; the read sees the value before the write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/quicksort_engine.sv]
// ----------------------------------------------------------------------------
// quicksort_engine
// Collects signed values, sorts them in place by quicksort and streams them
// out in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one value per item. Items are loaded into the element memory
//   at one item per cycle; values beyond DEPTH are dropped. An item with
//   last set ends the set and starts the sort, and in_ch.ready stays low
//   until the whole set has been delivered.
//   The sort runs Lomuto partitions with the first element of each range as
//   pivot; pending ranges live on a stack memory. Each partition pops the
//   range, fetches the pivot, compares each further element in turn with an
//   extra step per swap, then places the pivot and pushes the sub-ranges;
//   the element memory's single read port serializes these steps.
//   Results leave on out_ch from an output register: each value is read
//   from memory, then loaded into the register once the previous one has
//   been taken; end_of_set marks the last. Once no range is left, the first
//   result follows the pop and output-load states. A stalled receiver
//   simply holds the output register; nothing is lost.
//   Reset (rst, synchronous) empties the set and the range stack and returns
//   to loading. The element memory is not cleared; only loaded entries are
//   ever read.
// ----------------------------------------------------------------------------
module quicksort_engine import qse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  qse_in_if.sink    in_ch,
  qse_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_SORT_INIT,
    S_POP,
    S_POP_WAIT,
    S_PIV,
    S_CMP,
    S_SWAP,
    S_FIN1,
    S_FIN2,
    S_PUSHL,
    S_OUT_LOAD,
    S_OUT_SEND
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [SP_W-1:0]          sp;
  logic [IDX_W-1:0]         lo;
  logic [IDX_W-1:0]         hi;
  logic [IDX_W-1:0]         i;
  logic [IDX_W-1:0]         j;
  logic [IDX_W-1:0]         k;
  logic signed [DATA_W-1:0] pivot;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;

  // Memory port signals.
  logic                st_we;
  logic [IDX_W-1:0]    st_waddr;
  logic [DATA_W-1:0]   st_wdata;
  logic [IDX_W-1:0]    st_raddr;
  logic [DATA_W-1:0]   st_rdata;
  logic                stk_we;
  logic [STK_ADDR_W-1:0] stk_waddr;
  range_t              stk_wdata;
  logic [STK_ADDR_W-1:0] stk_raddr;
  logic [RANGE_W-1:0]  stk_rdata;
  range_t              popped;

  // Helper values.
  logic                in_fire;
  logic                less;
  logic [IDX_W-1:0]    j_inc;
  logic [IDX_W-1:0]    i_inc;
  logic [CNT_W-1:0]    count_m1;
  logic [SP_W-1:0]     sp_m1;
  logic                stk_room;
  logic                push_right;
  logic                push_left;

  assign in_ch.ready         = (state == S_LOAD);
  assign in_fire             = in_ch.valid && (state == S_LOAD);
  assign out_ch.valid        = out_valid;
  assign out_ch.sorted_value = out_value;
  assign out_ch.end_of_set   = out_last;

  assign popped     = range_t'(stk_rdata);
  assign less       = $signed(st_rdata) < pivot;
  assign j_inc      = j + IDX_W'(1);
  assign i_inc      = i + IDX_W'(1);
  assign count_m1   = count - CNT_W'(1);
  assign sp_m1      = sp - SP_W'(1);
  assign stk_room   = sp < SP_W'(STACK_DEPTH);
  assign push_right = ({1'b0, hi} > ({1'b0, j} + CNT_W'(1))) && stk_room;
  assign push_left  = ({1'b0, j} > ({1'b0, lo} + CNT_W'(1))) && stk_room;

  qse_ram #(.WIDTH(DATA_W), .ADDR_W(IDX_W)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  qse_ram #(.WIDTH(RANGE_W), .ADDR_W(STK_ADDR_W)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Memory accesses for each step of the sequencer.
  always_comb begin
    st_we     = 1'b0;
    st_waddr  = i;
    st_wdata  = st_rdata;
    st_raddr  = i_inc;
    stk_we    = 1'b0;
    stk_waddr = sp[STK_ADDR_W-1:0];
    stk_wdata = '{lo: lo, hi: hi};
    stk_raddr = sp_m1[STK_ADDR_W-1:0];
    case (state)
      S_LOAD: begin
        st_we    = in_fire && (count < CNT_W'(DEPTH));
        st_waddr = count[IDX_W-1:0];
        st_wdata = in_ch.value;
      end
      S_SORT_INIT: begin
        stk_we    = count > CNT_W'(1);
        stk_wdata = '{lo: '0, hi: count_m1[IDX_W-1:0]};
      end
      S_POP: begin
        st_raddr = '0;
      end
      S_POP_WAIT: begin
        st_raddr = popped.lo;
      end
      S_PIV: begin
        st_raddr = lo + IDX_W'(1);
      end
      S_CMP: begin
        // A smaller element goes to j+1; the old j+1 value is read back
        // in the same cycle and lands at i in the next one.
        if (less) begin
          st_we    = 1'b1;
          st_waddr = j_inc;
          st_wdata = st_rdata;
          st_raddr = j_inc;
        end
      end
      S_SWAP: begin
        st_we    = 1'b1;
        st_waddr = i;
        st_wdata = st_rdata;
      end
      S_FIN1: begin
        st_we    = 1'b1;
        st_waddr = j;
        st_wdata = pivot;
        st_raddr = j;
      end
      S_FIN2: begin
        st_we     = 1'b1;
        st_waddr  = lo;
        st_wdata  = st_rdata;
        stk_we    = push_right;
        stk_wdata = '{lo: j_inc, hi: hi};
      end
      S_PUSHL: begin
        stk_we    = push_left;
        stk_wdata = '{lo: lo, hi: j - IDX_W'(1)};
      end
      S_OUT_SEND: begin
        st_raddr = k + IDX_W'(1);
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  // Sequencer: load, partition ranges from the stack, then stream out.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (count < CNT_W'(DEPTH)) begin
              count <= count + CNT_W'(1);
            end
            if (in_ch.last) begin
              state <= S_SORT_INIT;
            end
          end
        end
        S_SORT_INIT: begin
          if (stk_we) begin
            sp <= sp + SP_W'(1);
          end
          state <= S_POP;
        end
        S_POP: begin
          if (sp == '0) begin
            k     <= '0;
            state <= S_OUT_LOAD;
          end else begin
            sp    <= sp_m1;
            state <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          lo    <= popped.lo;
          hi    <= popped.hi;
          state <= S_PIV;
        end
        S_PIV: begin
          pivot <= st_rdata;
          j     <= lo;
          i     <= lo + IDX_W'(1);
          state <= S_CMP;
        end
        S_CMP: begin
          if (less) begin
            j     <= j_inc;
            state <= S_SWAP;
          end else if (i == hi) begin
            state <= S_FIN1;
          end else begin
            i <= i_inc;
          end
        end
        S_SWAP: begin
          if (i == hi) begin
            state <= S_FIN1;
          end else begin
            i     <= i_inc;
            state <= S_CMP;
          end
        end
        S_FIN1: begin
          state <= S_FIN2;
        end
        S_FIN2: begin
          if (stk_we) begin
            sp <= sp + SP_W'(1);
          end
          state <= S_PUSHL;
        end
        S_PUSHL: begin
          if (stk_we) begin
            sp <= sp + SP_W'(1);
          end
          state <= S_POP;
        end
        S_OUT_LOAD: begin
          out_valid <= 1'b1;
          out_value <= st_rdata;
          out_last  <= ({1'b0, k} == count_m1);
          state     <= S_OUT_SEND;
        end
        S_OUT_SEND: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              state <= S_LOAD;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_OUT_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

[hw/rtl/qse_checker.sv]
// ----------------------------------------------------------------------------
// qse_checker
// Port-level checks for the quicksort engine, bound to the top level.
// ----------------------------------------------------------------------------
module qse_checker import qse_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_value,
  input logic              out_end
);

  // A pending result is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_end))
    else $error("result item changed while stalled");

  // Loading and delivering never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // Once a set is closed, the input is no longer ready right after its last item is taken.
  a_closed_set: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after the last item of a set");

endmodule

bind quicksort_engine qse_checker u_qse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.sorted_value),
  .out_end   (out_ch.end_of_set)
);
